// ===== src/tea_pkg.sv =====
`timescale 1ns / 1ps

package tea_pkg;

   // round constant of the cipher
   localparam logic [31:0] DELTA = 32'h9E37_79B9;

   // data word width
   localparam int WORD_WIDTH = 32;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_KEY_WORD_0 = 2'd0,
      REG_KEY_WORD_1 = 2'd1,
      REG_KEY_WORD_2 = 2'd2,
      REG_KEY_WORD_3 = 2'd3
   } reg_index_type;

   // operation selected per item
   typedef enum logic {
      MODE_ENCRYPT = 1'b0,
      MODE_DECRYPT = 1'b1
   } mode_type;

   // the 128-bit key as four words
   typedef struct packed {
      logic [WORD_WIDTH-1:0] k3;
      logic [WORD_WIDTH-1:0] k2;
      logic [WORD_WIDTH-1:0] k1;
      logic [WORD_WIDTH-1:0] k0;
   } key_type;

   // one block in flight through the pipeline
   typedef struct packed {
      mode_type              mode;
      logic [WORD_WIDTH-1:0] y;
      logic [WORD_WIDTH-1:0] z;
   } item_type;

   // round mixing function
   function automatic logic [WORD_WIDTH-1:0] mix(
      input logic [WORD_WIDTH-1:0] v,
      input logic [WORD_WIDTH-1:0] s,
      input logic [WORD_WIDTH-1:0] ka,
      input logic [WORD_WIDTH-1:0] kb
   );
      logic [WORD_WIDTH-1:0] shl_sum;
      logic [WORD_WIDTH-1:0] shr_sum;
      shl_sum = (v << 4) + ka;
      shr_sum = (v >> 5) + kb;
      return shl_sum ^ (v + s) ^ shr_sum;
   endfunction

endpackage

// ===== src/tea_csr.sv =====
`timescale 1ns / 1ps

module tea_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output tea_pkg::key_type    key
);

   tea_pkg::key_type    key_ff;
   tea_pkg::key_type    key_in;
   tea_pkg::reg_index_type reg_index;
   logic                write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = tea_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // key register write decode
   always_comb begin
      key_in = key_ff;
      if (write_en) begin
         unique case (reg_index)
            tea_pkg::REG_KEY_WORD_0: key_in.k0 = csr_pwdata;
            tea_pkg::REG_KEY_WORD_1: key_in.k1 = csr_pwdata;
            tea_pkg::REG_KEY_WORD_2: key_in.k2 = csr_pwdata;
            tea_pkg::REG_KEY_WORD_3: key_in.k3 = csr_pwdata;
            default:                 key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_index)
         tea_pkg::REG_KEY_WORD_0: csr_prdata = key_ff.k0;
         tea_pkg::REG_KEY_WORD_1: csr_prdata = key_ff.k1;
         tea_pkg::REG_KEY_WORD_2: csr_prdata = key_ff.k2;
         tea_pkg::REG_KEY_WORD_3: csr_prdata = key_ff.k3;
         default:                 csr_prdata = '0;
      endcase
   end

   assign key = key_ff;

endmodule

// ===== src/tea_round_stage.sv =====
`timescale 1ns / 1ps

module tea_round_stage #(
   parameter int ROUNDS      = 32,
   parameter int ROUND_INDEX = 0,
   parameter int HALF        = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  tea_pkg::key_type    key,
   input  logic                in_valid,
   output logic                in_ready,
   input  tea_pkg::item_type   in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output tea_pkg::item_type   out_item
);

   // running sum of this round, fixed per stage
   localparam logic [63:0] EncProd = 64'(tea_pkg::DELTA) * 64'(ROUND_INDEX + 1);
   localparam logic [63:0] DecProd = 64'(tea_pkg::DELTA) * 64'(ROUNDS - ROUND_INDEX);
   localparam logic [31:0] EncSum  = EncProd[31:0];
   localparam logic [31:0] DecSum  = DecProd[31:0];
   localparam logic        SecondHalf = (HALF != 0);

   logic                     valid_ff;
   tea_pkg::item_type        item_ff;
   tea_pkg::item_type        item_in;
   logic                     decrypt;
   logic                     update_y;
   logic [31:0]              round_sum;
   logic [31:0]              src_word;
   logic [31:0]              dst_word;
   logic [31:0]              ka;
   logic [31:0]              kb;
   logic [31:0]              mixed;
   logic [31:0]              new_word;

   assign in_ready = !valid_ff || out_ready;

   // encrypt updates y then z, decrypt updates z then y
   assign decrypt   = (in_item.mode == tea_pkg::MODE_DECRYPT);
   assign update_y  = !(decrypt ^ SecondHalf);
   assign round_sum = decrypt ? DecSum : EncSum;
   assign src_word  = update_y ? in_item.z : in_item.y;
   assign dst_word  = update_y ? in_item.y : in_item.z;
   assign ka        = update_y ? key.k0 : key.k2;
   assign kb        = update_y ? key.k1 : key.k3;
   assign mixed     = tea_pkg::mix(src_word, round_sum, ka, kb);
   assign new_word  = decrypt ? (dst_word - mixed) : (dst_word + mixed);

   always_comb begin
      item_in = in_item;
      if (update_y) begin
         item_in.y = new_word;
      end else begin
         item_in.z = new_word;
      end
   end

   // stage register, held while downstream stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== src/tea_block_cipher_unit.sv =====
`timescale 1ns / 1ps

// channel  | ports      | content
// ---------+------------+---------------------------------------------------
// request  | req_t*     | tuser: mode; tdata: block_first_word, second_word
// response | rsp_t*     | tdata: result_first_word, result_second_word
// config   | csr_p*     | key_word_0..3 at byte addresses 0, 4, 8, 12
//
// one half-round per stage
// one transfer per cycle sustained on both sides when rsp_tready stays high
// reset clears the stage valid bits and the key registers to zero
// a stall on rsp_tready fills empty stages first, then holds each stage in place
module tea_block_cipher_unit #(
   parameter int ROUNDS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [0:0]   req_tuser,   // [0] mode
   input  logic [63:0]  req_tdata,   // [31:0] block_first_word, [63:32] block_second_word
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // [31:0] result_first_word, [63:32] result_second_word
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int Stages = 2 * ROUNDS;
   localparam int CountWidth = $clog2(Stages + 1);

   tea_pkg::key_type    key;
   logic [Stages:0]     valid_chain;
   logic [Stages:0]     ready_chain;
   tea_pkg::item_type   item_chain [Stages+1];

   // key registers
   tea_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key         (key)
   );

   // input side of the pipeline
   assign valid_chain[0]     = req_tvalid;
   assign req_tready         = ready_chain[0];
   assign item_chain[0].mode = tea_pkg::mode_type'(req_tuser[0]);
   assign item_chain[0].y    = req_tdata[31:0];
   assign item_chain[0].z    = req_tdata[63:32];

   // one stage per half-round
   for (genvar i = 0; i < Stages; i++) begin : g_stage
      tea_round_stage #(
         .ROUNDS      (ROUNDS),
         .ROUND_INDEX (i / 2),
         .HALF        (i % 2)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .key       (key),
         .in_valid  (valid_chain[i]),
         .in_ready  (ready_chain[i]),
         .in_item   (item_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_ready (ready_chain[i+1]),
         .out_item  (item_chain[i+1])
      );
   end

   // last stage is the output register
   assign rsp_tvalid          = valid_chain[Stages];
   assign ready_chain[Stages] = rsp_tready;
   assign rsp_tdata           = {item_chain[Stages].z, item_chain[Stages].y};

   // items in flight, tracked at the ports
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  take_in;
   logic                  give_out;

   assign take_in  = req_tvalid && req_tready;
   assign give_out = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (take_in && !give_out) begin
         count_in = count_ff + CountWidth'(1);
      end else if (give_out && !take_in) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // an empty output stage lets every stage move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with the output stage empty");

   // stage valid bits match the port-level count
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_chain[Stages:1]) == int'(count_ff))
      else $error("items lost or duplicated in the pipeline");

   // an accepted item lands in the first stage
   a_first_stage_loaded: assert property (@(posedge clock) disable iff (reset)
      take_in |=> valid_chain[1])
      else $error("accepted item missing from the first stage");

   // never more items than stages
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= Stages)
      else $error("more items in flight than stages");

endmodule
